// ===== rtl/core/ptp_pkg.sv =====
// ptp_pkg: opcodes, field widths and the queued command type of the thread picker
// shared by the front end, the command queue and the scheduling back end
// no dependencies
`default_nettype none

package ptp_pkg;

  localparam int SLOT_IDX_W  = 4;
  localparam int PRIO_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESCHED = 2'd1,
    OP_YIELD   = 2'd2,
    OP_EXIT    = 2'd3
  } ptp_op_t;

  // one classified item as it travels from the front end to the back end
  typedef struct packed {
    logic                  wr;
    logic                  yield;
    logic                  exit;
    logic [SLOT_IDX_W-1:0] slot;
    logic [PRIO_W-1:0]     prio;
    logic                  rdy;
  } ptp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptp_front.sv =====
// ptp_front: takes items on the command port, classifies them and drops ignored writes
// depends on ptp_pkg
`default_nettype none

module ptp_front #(
  parameter int SLOT_COUNT      = 16,
  parameter int PRIORITY_LEVELS = 32
) (
  input  wire logic                           start,
  input  wire logic                           queue_full,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [ptp_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  wire logic [ptp_pkg::PRIO_W-1:0]     in_priority_value,
  input  wire logic                           in_ready_flag,
  output logic                                push,
  output ptp_pkg::ptp_cmd_t                   push_cmd
);
  import ptp_pkg::*;

  ptp_op_t op;
  logic    accept;
  logic    idx_ok;
  logic    prio_ok;
  logic    keep;

  always_comb begin
    op      = ptp_op_t'(in_opcode);
    accept  = start && !queue_full;
    idx_ok  = (9'(in_slot_index) < 9'(SLOT_COUNT));
    prio_ok = (9'(in_priority_value) < 9'(PRIORITY_LEVELS));
    push_cmd.slot = in_slot_index;
    push_cmd.prio = in_priority_value;
    push_cmd.rdy  = in_ready_flag;
    push_cmd.wr    = 1'b0;
    push_cmd.yield = 1'b0;
    push_cmd.exit  = 1'b0;
    keep = 1'b1;
    case (op)
      OP_WRITE: begin
        push_cmd.wr = 1'b1;
        // a write out of range is dropped as a whole
        keep = idx_ok && prio_ok;
      end
      OP_RESCHED: begin
        push_cmd.yield = 1'b0;
      end
      OP_YIELD: begin
        push_cmd.yield = 1'b1;
      end
      OP_EXIT: begin
        push_cmd.yield = 1'b1;
        push_cmd.exit  = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    push = accept && keep;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptp_queue.sv =====
// ptp_queue: short command queue between the front end and the back end
// depends on ptp_pkg
`default_nettype none

module ptp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire ptp_pkg::ptp_cmd_t  push_cmd,
  input  wire logic               pop,
  output ptp_pkg::ptp_cmd_t       pop_cmd,
  output logic                    empty,
  output logic                    full
);
  import ptp_pkg::*;

  ptp_cmd_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_cmd = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ptp_back.sv =====
// ptp_back: slot table, current slot and switch counter; runs writes and one-slot-a-cycle picks
// depends on ptp_pkg
`default_nettype none

module ptp_back #(
  parameter int SLOT_COUNT      = 16,
  parameter int STAMP_WIDTH     = 32,
  parameter int PRIORITY_LEVELS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire ptp_pkg::ptp_cmd_t               q_cmd,
  output logic                                 q_pop,
  output logic                                 out_valid,
  output logic                                 out_found,
  output logic [ptp_pkg::SLOT_IDX_W-1:0]       out_chosen_slot,
  output logic                                 out_switched
);
  import ptp_pkg::*;

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int IW    = (SW > SLOT_IDX_W) ? SW : SLOT_IDX_W;
  localparam int PLW   = $clog2(PRIORITY_LEVELS);
  localparam int PRW   = (PLW < PRIO_W) ? PLW : PRIO_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t                 state_r;
  logic [SLOT_COUNT-1:0]  present_r;
  logic [SLOT_COUNT-1:0]  ready_r;
  logic [SW-1:0]          cur_r;
  logic                   has_cur_r;
  logic [STAMP_WIDTH-1:0] seq_r;
  logic                   have_self_r;
  logic                   yield_r;
  logic [SW-1:0]          scan_r;
  logic                   cand_vld_r;
  logic [SW-1:0]          cand_idx_r;
  logic                   cand_run_r;
  logic [PRW-1:0]         cand_prio_r;
  logic [STAMP_WIDTH-1:0] cand_stamp_r;
  logic                   best_vld_r;
  logic [SW-1:0]          best_idx_r;
  logic [PRW-1:0]         best_prio_r;
  logic [STAMP_WIDTH-1:0] best_stamp_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [SLOT_IDX_W-1:0]  out_chosen_slot_r;
  logic                   out_switched_r;

  logic [PRW-1:0]         prio_mem  [SLOT_COUNT];
  logic [STAMP_WIDTH-1:0] stamp_mem [SLOT_COUNT];

  logic [IW-1:0]          cmd_wide;
  logic [SW-1:0]          cmd_slot;
  logic                   take;
  logic                   cand_self;
  logic                   best_self;
  logic                   best_vld_nxt;
  logic [SW-1:0]          best_idx_nxt;
  logic [PRW-1:0]         best_prio_nxt;
  logic [STAMP_WIDTH-1:0] best_stamp_nxt;
  logic                   keep_cur;
  logic [STAMP_WIDTH-1:0] seq_nxt;
  logic [IW-1:0]          best_wide;
  logic                   stamp_we;
  logic [SW-1:0]          stamp_addr;
  logic [STAMP_WIDTH-1:0] stamp_data;

  assign cmd_wide = IW'(q_cmd.slot);
  assign cmd_slot = cmd_wide[SW-1:0];
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;

  // compare the registered candidate with the best so far, in slot order
  always_comb begin
    cand_self = have_self_r && (cand_idx_r == cur_r);
    best_self = have_self_r && (best_idx_r == cur_r);
    take = 1'b0;
    if (cand_vld_r && cand_run_r) begin
      if (!best_vld_r || (cand_prio_r < best_prio_r)) begin
        take = 1'b1;
      end else if (cand_prio_r == best_prio_r) begin
        if (!yield_r) begin
          if (best_self) take = 1'b0;
          else if (cand_self) take = 1'b1;
          else take = (cand_stamp_r < best_stamp_r);
        end else begin
          if (best_self) take = 1'b1;
          else if (cand_self) take = 1'b0;
          else take = (cand_stamp_r < best_stamp_r);
        end
      end
    end
    best_vld_nxt   = best_vld_r || take;
    best_idx_nxt   = take ? cand_idx_r   : best_idx_r;
    best_prio_nxt  = take ? cand_prio_r  : best_prio_r;
    best_stamp_nxt = take ? cand_stamp_r : best_stamp_r;
    keep_cur  = have_self_r && (best_idx_nxt == cur_r);
    seq_nxt   = seq_r + 1'b1;
    best_wide = IW'(best_idx_nxt);
  end

  // single stamp write port: slot setup clears, a switch stamps
  always_comb begin
    stamp_we   = 1'b0;
    stamp_addr = cmd_slot;
    stamp_data = '0;
    if (q_pop && q_cmd.wr && !present_r[cmd_slot]) begin
      stamp_we = 1'b1;
    end else if ((state_r == ST_DRAIN) && best_vld_nxt && !keep_cur) begin
      stamp_we   = 1'b1;
      stamp_addr = best_idx_nxt;
      stamp_data = seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      present_r         <= '0;
      ready_r           <= '0;
      cur_r             <= '0;
      has_cur_r         <= 1'b0;
      seq_r             <= '0;
      cand_vld_r        <= 1'b0;
      best_vld_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      out_found_r       <= 1'b0;
      out_chosen_slot_r <= '0;
      out_switched_r    <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_DRAIN);
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_cmd.wr) begin
              present_r[cmd_slot] <= 1'b1;
              ready_r[cmd_slot]   <= q_cmd.rdy;
            end else begin
              if (q_cmd.exit && has_cur_r) begin
                present_r[cur_r] <= 1'b0;
                ready_r[cur_r]   <= 1'b0;
              end
              if (q_cmd.exit) has_cur_r <= 1'b0;
              have_self_r <= has_cur_r && !q_cmd.exit;
              yield_r     <= q_cmd.yield;
              scan_r      <= '0;
              cand_vld_r  <= 1'b0;
              best_vld_r  <= 1'b0;
              state_r     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cand_vld_r <= 1'b1;
          best_vld_r <= best_vld_nxt;
          if (scan_r == LAST_SLOT) begin
            state_r <= ST_DRAIN;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          cand_vld_r        <= 1'b0;
          out_found_r       <= best_vld_nxt;
          out_chosen_slot_r <= best_vld_nxt ? best_wide[SLOT_IDX_W-1:0] : '0;
          out_switched_r    <= best_vld_nxt && !keep_cur;
          if (best_vld_nxt && !keep_cur) begin
            seq_r     <= seq_nxt;
            cur_r     <= best_idx_nxt;
            has_cur_r <= 1'b1;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // candidate pipeline and best-so-far payload
  always_ff @(posedge clk) begin
    cand_idx_r   <= scan_r;
    cand_run_r   <= present_r[scan_r] && ready_r[scan_r];
    best_idx_r   <= best_idx_nxt;
    best_prio_r  <= best_prio_nxt;
    best_stamp_r <= best_stamp_nxt;
  end

  // slot table memories, one read address (the scan) and one write address per memory
  always_ff @(posedge clk) begin
    cand_prio_r  <= prio_mem[scan_r];
    cand_stamp_r <= stamp_mem[scan_r];
    if (q_pop && q_cmd.wr) prio_mem[cmd_slot] <= q_cmd.prio[PRW-1:0];
    if (stamp_we) stamp_mem[stamp_addr] <= stamp_data;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_chosen_slot = out_chosen_slot_r;
  assign out_switched    = out_switched_r;

  a_drain_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> out_valid_r)
    else $error("pick finished without a result transfer");

  a_result_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DRAIN))
    else $error("result transfer without a finished pick");

  a_empty_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_chosen_slot_r == '0 && !out_switched_r))
    else $error("empty pick carries a slot or a switch");

  a_switch_sets_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_switched_r) |-> has_cur_r)
    else $error("switch reported but no current slot");

endmodule

`default_nettype wire

// ===== rtl/core/priority_thread_picker_unit.sv =====
// Strict-priority thread picker; ties keep the owner unless it yields, then the oldest switch-in.
// A schedule item's result strobe rises after the command queue, the idle state, the slot scan,
// the drain state and the result register; the scan holds the back end, a write only the idle state.
// Throughput is set by the pick scanning one slot a cycle through the slot table read port;
// busy rises when the two-entry command queue is full. The receiver cannot stall results.
// Synchronous reset: slot table empty, no current slot, switch counter at zero.
`default_nettype none

module priority_thread_picker_unit #(
  parameter int SLOT_COUNT      = 16,
  parameter int STAMP_WIDTH     = 32,
  parameter int PRIORITY_LEVELS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [ptp_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  wire logic [ptp_pkg::PRIO_W-1:0]     in_priority_value,
  input  wire logic                           in_ready_flag,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [ptp_pkg::SLOT_IDX_W-1:0]      out_chosen_slot,
  output logic                                out_switched
);
  import ptp_pkg::*;

  logic     push;
  ptp_cmd_t push_cmd;
  logic     pop;
  ptp_cmd_t pop_cmd;
  logic     q_empty;
  logic     q_full;

  assign busy = q_full;

  ptp_front #(
    .SLOT_COUNT      (SLOT_COUNT),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_front (
    .start             (start),
    .queue_full        (q_full),
    .in_opcode         (in_opcode),
    .in_slot_index     (in_slot_index),
    .in_priority_value (in_priority_value),
    .in_ready_flag     (in_ready_flag),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  ptp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  ptp_back #(
    .SLOT_COUNT      (SLOT_COUNT),
    .STAMP_WIDTH     (STAMP_WIDTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_chosen_slot (out_chosen_slot),
    .out_switched    (out_switched)
  );

endmodule

`default_nettype wire

// ===== verif/priority_thread_picker_checker.sv =====
// priority_thread_picker_checker: watches the command and result ports of the thread picker,
// keeps its own copy of the slot table, predicts every pick and compares it field by field
// depends on ptp_pkg for the opcode enum and field widths
`default_nettype none

module priority_thread_picker_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic [1:0]                     in_opcode,
  input  wire logic [ptp_pkg::SLOT_IDX_W-1:0] in_slot_index,
  input  wire logic [ptp_pkg::PRIO_W-1:0]     in_priority_value,
  input  wire logic                           in_ready_flag,
  input  wire logic                           out_valid,
  input  wire logic                           out_found,
  input  wire logic [ptp_pkg::SLOT_IDX_W-1:0] out_chosen_slot,
  input  wire logic                           out_switched,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  picks_checked,
  output int                                  switches_seen,
  output int                                  idle_picks_seen
);
  import ptp_pkg::*;

  localparam int NUM_SLOTS = 16;

  typedef struct {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot;
    logic                  switched;
  } pick_t;

  // shadow of the slot table and the current owner
  logic                  slot_live  [NUM_SLOTS];
  logic [PRIO_W-1:0]     slot_level [NUM_SLOTS];
  logic                  slot_go    [NUM_SLOTS];
  logic [31:0]           slot_age   [NUM_SLOTS];
  logic [SLOT_IDX_W-1:0] owner;
  logic                  owner_valid;
  logic [31:0]           switch_count;

  pick_t picks_due[$];

  // best runnable slot: lowest level, then owner unless yielding, then oldest stamp, lowest index
  function automatic int best_slot(input logic self_ok, input logic [SLOT_IDX_W-1:0] self_idx,
                                   input logic yielding);
    int   best;
    logic cand_self;
    logic best_self;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!(slot_live[i] && slot_go[i])) continue;
      if (best < 0 || slot_level[i] < slot_level[best]) begin
        best = i;
        continue;
      end
      if (slot_level[i] != slot_level[best]) continue;
      cand_self = self_ok && (i == self_idx);
      best_self = self_ok && (best == self_idx);
      if (!yielding) begin
        if (best_self) continue;
        if (cand_self) begin
          best = i;
          continue;
        end
      end else begin
        if (best_self) begin
          best = i;
          continue;
        end
        if (cand_self) continue;
      end
      if (slot_age[i] < slot_age[best]) best = i;
    end
    return best;
  endfunction

  task automatic predict_pick(input ptp_op_t op);
    logic  self_ok;
    logic  yielding;
    int    winner;
    pick_t p;
    self_ok  = owner_valid;
    yielding = (op != OP_RESCHED);
    if (op == OP_EXIT) begin
      if (owner_valid) begin
        slot_live[owner] = 1'b0;
        slot_go[owner]   = 1'b0;
      end
      self_ok     = 1'b0;
      owner_valid = 1'b0;
    end
    winner = best_slot(self_ok, owner, yielding);
    if (winner < 0) begin
      p = '{found: 1'b0, slot: '0, switched: 1'b0};
    end else if (self_ok && winner == owner) begin
      p = '{found: 1'b1, slot: winner[SLOT_IDX_W-1:0], switched: 1'b0};
    end else begin
      switch_count     = switch_count + 32'd1;
      slot_age[winner] = switch_count;
      owner            = winner[SLOT_IDX_W-1:0];
      owner_valid      = 1'b1;
      p = '{found: 1'b1, slot: winner[SLOT_IDX_W-1:0], switched: 1'b1};
    end
    picks_due.insert(picks_due.size(), p);
  endtask

  always @(posedge clk) begin
    pick_t exp;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_live[i]  = 1'b0;
        slot_level[i] = '0;
        slot_go[i]    = 1'b0;
        slot_age[i]   = '0;
      end
      owner        = '0;
      owner_valid  = 1'b0;
      switch_count = '0;
      picks_due.delete();
    end else begin
      // results are compared before the transfer of this edge is predicted
      if (out_valid) begin
        if (picks_due.size() == 0) begin
          $error("unexpected result: found=%0d chosen_slot=%0d switched=%0d",
                 out_found, out_chosen_slot, out_switched);
          fail_count++;
        end else begin
          exp = picks_due[0];
          picks_due.delete(0);
          picks_checked++;
          if (exp.switched) switches_seen++;
          if (!exp.found) idle_picks_seen++;
          if (out_found !== exp.found) begin
            $error("found: expected %0d, actual %0d", exp.found, out_found);
            fail_count++;
          end
          if (out_chosen_slot !== exp.slot) begin
            $error("chosen_slot: expected %0d, actual %0d", exp.slot, out_chosen_slot);
            fail_count++;
          end
          if (out_switched !== exp.switched) begin
            $error("switched: expected %0d, actual %0d", exp.switched, out_switched);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (ptp_op_t'(in_opcode) == OP_WRITE) begin
          // a slot coming into the table starts with the oldest stamp
          if (!slot_live[in_slot_index]) slot_age[in_slot_index] = '0;
          slot_live[in_slot_index]  = 1'b1;
          slot_level[in_slot_index] = in_priority_value;
          slot_go[in_slot_index]    = in_ready_flag;
        end else begin
          predict_pick(ptp_op_t'(in_opcode));
        end
      end
    end
    pending = picks_due.size();
  end

endmodule

`default_nettype wire

// ===== verif/priority_thread_picker_unit_tb.sv =====
// priority_thread_picker_unit_tb: drives directed and random slot writes and picks into the
// thread picker with random gaps, and gives the verdict from the checker's failure and pending counts
// depends on ptp_pkg, priority_thread_picker_unit and priority_thread_picker_checker
`default_nettype none

module priority_thread_picker_unit_tb;
  import ptp_pkg::*;

  localparam int RUN_LIMIT  = 400000;
  localparam int DRAIN_WAIT = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_opcode;
  logic [SLOT_IDX_W-1:0] in_slot_index;
  logic [PRIO_W-1:0]     in_priority_value;
  logic                  in_ready_flag;
  logic                  out_valid;
  logic                  out_found;
  logic [SLOT_IDX_W-1:0] out_chosen_slot;
  logic                  out_switched;

  int fail_count;
  int pending;
  int picks_checked;
  int switches_seen;
  int idle_picks_seen;
  int cycle_count;
  int op_tally[4];

  priority_thread_picker_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_slot_index     (in_slot_index),
    .in_priority_value (in_priority_value),
    .in_ready_flag     (in_ready_flag),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_chosen_slot   (out_chosen_slot),
    .out_switched      (out_switched)
  );

  priority_thread_picker_checker pick_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_slot_index     (in_slot_index),
    .in_priority_value (in_priority_value),
    .in_ready_flag     (in_ready_flag),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_chosen_slot   (out_chosen_slot),
    .out_switched      (out_switched),
    .fail_count        (fail_count),
    .pending           (pending),
    .picks_checked     (picks_checked),
    .switches_seen     (switches_seen),
    .idle_picks_seen   (idle_picks_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // holds the command until a transfer happens; start stays high for a back-to-back item
  task automatic send_cmd(input ptp_op_t op, input logic [SLOT_IDX_W-1:0] idx,
                          input logic [PRIO_W-1:0] prio, input logic rdy);
    @(negedge clk);
    start             <= 1'b1;
    in_opcode         <= op;
    in_slot_index     <= idx;
    in_priority_value <= prio;
    in_ready_flag     <= rdy;
    do @(posedge clk); while (busy);
    op_tally[op]++;
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_all_picks();
    hold_off(1);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_write(input int idx, input int prio, input logic rdy);
    send_cmd(OP_WRITE, idx[SLOT_IDX_W-1:0], prio[PRIO_W-1:0], rdy);
  endtask

  task automatic send_pick(input ptp_op_t op);
    send_cmd(op, SLOT_IDX_W'($urandom_range(0, 15)), PRIO_W'($urandom_range(0, 31)),
             1'($urandom_range(0, 1)));
  endtask

  task automatic send_random();
    int      r;
    ptp_op_t op;
    logic [PRIO_W-1:0] prio;
    r = $urandom_range(0, 99);
    if (r < 40)      op = OP_WRITE;
    else if (r < 65) op = OP_RESCHED;
    else if (r < 85) op = OP_YIELD;
    else             op = OP_EXIT;
    // narrow priorities most of the time so ties and tie-breaks come up often
    if ($urandom_range(0, 3) == 0) prio = PRIO_W'($urandom_range(0, 31));
    else                           prio = PRIO_W'($urandom_range(0, 3));
    send_cmd(op, SLOT_IDX_W'($urandom_range(0, 15)), prio, $urandom_range(0, 3) != 0);
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)      return;
    else if (r < 90) hold_off($urandom_range(1, 4));
    else             hold_off($urandom_range(10, 40));
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_opcode         = '0;
    in_slot_index     = '0;
    in_priority_value = '0;
    in_ready_flag     = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty table: nothing runnable, exit without an owner
    send_pick(OP_RESCHED);
    send_pick(OP_YIELD);
    send_pick(OP_EXIT);
    send_write(0, 31, 1'b1);
    send_write(15, 0, 1'b0);
    send_pick(OP_RESCHED);
    send_pick(OP_RESCHED);
    send_write(15, 0, 1'b1);
    hold_off(3);
    send_pick(OP_YIELD);
    // equal priority: owner kept on reschedule, handed over on yield
    send_write(5, 0, 1'b1);
    send_pick(OP_RESCHED);
    send_pick(OP_YIELD);
    send_write(5, 0, 1'b1);
    send_write(10, 0, 1'b1);
    send_write(3, 0, 1'b1);
    send_pick(OP_YIELD);
    send_pick(OP_EXIT);
    send_write(10, 0, 1'b0);
    send_pick(OP_RESCHED);
    send_write(15, 31, 1'b1);
    send_write(5, 31, 1'b1);
    send_pick(OP_EXIT);
    send_pick(OP_EXIT);
    send_pick(OP_EXIT);
    send_pick(OP_EXIT);
    send_pick(OP_RESCHED);
    wait_all_picks();

    for (int blk = 0; blk < 8; blk++) begin
      for (int n = 0; n < 100; n++) begin
        send_random();
        if (blk != 2 && blk != 5) random_gap();
      end
      if (blk == 4) wait_all_picks();
    end
    hold_off(1);

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("sent %0d slot writes, %0d reschedules, %0d yields, %0d exits",
             op_tally[OP_WRITE], op_tally[OP_RESCHED], op_tally[OP_YIELD], op_tally[OP_EXIT]);
    $display("checked %0d picks: %0d switches, %0d with no runnable slot",
             picks_checked, switches_seen, idle_picks_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
